@@ rtl/core/linear_model_predict_with_fit_stats_defines.svh @@
// Assertion macros shared by the checker files of this block.
// Each macro clocks on clk; the first is disabled while rst_n is low.
`ifndef LINEAR_MODEL_PREDICT_WITH_FIT_STATS_DEFINES_SVH
`define LINEAR_MODEL_PREDICT_WITH_FIT_STATS_DEFINES_SVH

// Property checked outside reset.
`define LMP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lmp assertion failed");

// Property checked at every edge, reset included.
`define LMP_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("lmp reset assertion failed");

`endif

@@ rtl/core/lmp_pkg.sv @@
package lmp_pkg;

  // Defaults for the top-level parameters.
  localparam int MAX_FEATURES_DEF   = 16;
  localparam int FRAC_BITS_DEF      = 16;
  localparam int ROW_COUNT_BITS_DEF = 16;

  // Field widths.
  localparam int OPC_W     = 3;
  localparam int IDX_W     = 5;
  localparam int VAL_W     = 32;
  localparam int FC_W      = 5;
  localparam int ST_W      = 2;
  localparam int CFG_IDX_W = 1;

  // Opcodes.
  localparam logic [OPC_W-1:0] OP_LOAD       = 3'd0;
  localparam logic [OPC_W-1:0] OP_FEATURE    = 3'd1;
  localparam logic [OPC_W-1:0] OP_CLOSE_OBS  = 3'd2;
  localparam logic [OPC_W-1:0] OP_CLOSE_PRED = 3'd3;
  localparam logic [OPC_W-1:0] OP_FINISH     = 3'd4;

  // Status codes.
  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_MISMATCH = 2'd1;
  localparam logic [ST_W-1:0] ST_ZERO_TSS = 2'd2;
  localparam logic [ST_W-1:0] ST_NO_ROWS  = 2'd3;

  // Result kinds.
  localparam logic KIND_ROW  = 1'b0;
  localparam logic KIND_STAT = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FEATURE_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESPONSE_MEAN = 1'b1;

  // Which result word the output register is loaded with.
  typedef enum logic [1:0] {
    RS_MISS,
    RS_PRED,
    RS_ROW,
    RS_STAT
  } res_sel_t;

  // Operand pair for the shared multiplier.
  typedef enum logic [1:0] {
    MS_FEAT,
    MS_RSS,
    MS_TSS
  } mul_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load;
    logic     coef_wr;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     acc_feat;
    logic     close;
    logic     diff;
    logic     add_rss;
    logic     add_tss;
    logic     div_start;
    logic     div_tss;
    logic     div_step;
    logic     sqrt_start;
    logic     sqrt_step;
    logic     rms_load;
    logic     r2_load;
    logic     out_load;
    res_sel_t out_sel;
  } lmp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [OPC_W-1:0] opcode;
    logic             match;
    logic             rows_zero;
    logic             tss_zero;
    logic             div_done;
    logic             sqrt_done;
  } lmp_stat_t;

endpackage

@@ rtl/core/lmp_channels.sv @@
// Input word channel.
interface lmp_in_if;
  logic                               valid;
  logic                               ready;
  logic [lmp_pkg::OPC_W-1:0]          opcode;
  logic [lmp_pkg::IDX_W-1:0]          coef_index;
  logic signed [lmp_pkg::VAL_W-1:0]   value;

  modport source (output valid, opcode, coef_index, value, input ready);
  modport sink   (input valid, opcode, coef_index, value, output ready);
endinterface

// Result word channel.
interface lmp_out_if;
  logic                               valid;
  logic                               ready;
  logic                               kind;
  logic signed [lmp_pkg::VAL_W-1:0]   predicted;
  logic signed [lmp_pkg::VAL_W-1:0]   residual;
  logic signed [lmp_pkg::VAL_W-1:0]   r_squared;
  logic [lmp_pkg::VAL_W-1:0]          rms_error;
  logic [lmp_pkg::ST_W-1:0]           status;

  modport source (output valid, kind, predicted, residual, r_squared, rms_error, status,
                  input ready);
  modport sink   (input valid, kind, predicted, residual, r_squared, rms_error, status,
                  output ready);
endinterface

@@ rtl/core/lmp_ctrl.sv @@
module lmp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  lmp_pkg::lmp_stat_t  stat,
  output lmp_pkg::lmp_cmd_t   cmd
);

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_EXEC = 11'b000_0000_0010,
    S_ACC  = 11'b000_0000_0100,
    S_DIFF = 11'b000_0000_1000,
    S_SQR  = 11'b000_0001_0000,
    S_SQT  = 11'b000_0010_0000,
    S_SQA  = 11'b000_0100_0000,
    S_DIV1 = 11'b000_1000_0000,
    S_SQRT = 11'b001_0000_0000,
    S_DIV2 = 11'b010_0000_0000,
    S_EMIT = 11'b100_0000_0000
  } state_t;

  state_t              state_r, state_nxt;
  lmp_pkg::res_sel_t   sel_r, sel_nxt;
  logic                out_valid_r, out_valid_nxt;

  // Sequencing of one word at a time through the datapath.
  always_comb begin
    cmd           = '0;
    cmd.mul_sel   = lmp_pkg::MS_FEAT;
    cmd.out_sel   = sel_r;
    state_nxt     = state_r;
    sel_nxt       = sel_r;
    in_ready      = (state_r == S_IDLE);
    cmd.load      = in_valid && in_ready;
    case (state_r)
      S_IDLE: begin
        if (cmd.load) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        case (stat.opcode)
          lmp_pkg::OP_LOAD: begin
            cmd.coef_wr = 1'b1;
            state_nxt   = S_IDLE;
          end
          lmp_pkg::OP_FEATURE: begin
            cmd.mul_en = 1'b1;
            state_nxt  = S_ACC;
          end
          lmp_pkg::OP_CLOSE_OBS, lmp_pkg::OP_CLOSE_PRED: begin
            cmd.close = 1'b1;
            if (!stat.match) begin
              sel_nxt   = lmp_pkg::RS_MISS;
              state_nxt = S_EMIT;
            end else if (stat.opcode == lmp_pkg::OP_CLOSE_PRED) begin
              sel_nxt   = lmp_pkg::RS_PRED;
              state_nxt = S_EMIT;
            end else begin
              state_nxt = S_DIFF;
            end
          end
          lmp_pkg::OP_FINISH: begin
            sel_nxt = lmp_pkg::RS_STAT;
            if (stat.rows_zero) begin
              state_nxt = S_EMIT;
            end else begin
              cmd.div_start = 1'b1;
              state_nxt     = S_DIV1;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_ACC: begin
        cmd.acc_feat = 1'b1;
        state_nxt    = S_IDLE;
      end
      S_DIFF: begin
        cmd.diff  = 1'b1;
        state_nxt = S_SQR;
      end
      S_SQR: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = lmp_pkg::MS_RSS;
        state_nxt   = S_SQT;
      end
      S_SQT: begin
        cmd.add_rss = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = lmp_pkg::MS_TSS;
        state_nxt   = S_SQA;
      end
      S_SQA: begin
        cmd.add_tss = 1'b1;
        sel_nxt     = lmp_pkg::RS_ROW;
        state_nxt   = S_EMIT;
      end
      S_DIV1: begin
        if (stat.div_done) begin
          cmd.sqrt_start = 1'b1;
          state_nxt      = S_SQRT;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_SQRT: begin
        if (stat.sqrt_done) begin
          cmd.rms_load = 1'b1;
          if (stat.tss_zero) begin
            state_nxt = S_EMIT;
          end else begin
            cmd.div_start = 1'b1;
            cmd.div_tss   = 1'b1;
            state_nxt     = S_DIV2;
          end
        end else begin
          cmd.sqrt_step = 1'b1;
        end
      end
      S_DIV2: begin
        if (stat.div_done) begin
          cmd.r2_load = 1'b1;
          state_nxt   = S_EMIT;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // The output register holds its word until the sink takes it.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sel_r       <= lmp_pkg::RS_MISS;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

@@ rtl/core/lmp_datapath.sv @@
module lmp_datapath #(
  parameter int MAX_FEATURES   = lmp_pkg::MAX_FEATURES_DEF,
  parameter int FRAC_BITS      = lmp_pkg::FRAC_BITS_DEF,
  parameter int ROW_COUNT_BITS = lmp_pkg::ROW_COUNT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  lmp_pkg::lmp_cmd_t                   cmd,
  output lmp_pkg::lmp_stat_t                  stat,
  input  logic [lmp_pkg::OPC_W-1:0]           in_opcode,
  input  logic [lmp_pkg::IDX_W-1:0]           in_coef_index,
  input  logic signed [lmp_pkg::VAL_W-1:0]    in_value,
  input  logic                                cfg_we,
  input  logic [lmp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lmp_pkg::VAL_W-1:0]           cfg_data,
  output logic                                out_kind,
  output logic signed [lmp_pkg::VAL_W-1:0]    out_predicted,
  output logic signed [lmp_pkg::VAL_W-1:0]    out_residual,
  output logic signed [lmp_pkg::VAL_W-1:0]    out_r_squared,
  output logic [lmp_pkg::VAL_W-1:0]           out_rms_error,
  output logic [lmp_pkg::ST_W-1:0]            out_status
);

  localparam int CI_W = $clog2(MAX_FEATURES + 1);
  localparam int FS_W = $clog2(MAX_FEATURES + 2);
  localparam int Q_W  = 64 + FRAC_BITS;
  localparam int QC_W = $clog2(Q_W + 1);
  localparam logic [Q_W-1:0]    R2_CAP = Q_W'(1) << 40;
  localparam logic signed [63:0] ONE_FX = 64'sd1 <<< FRAC_BITS;
  localparam logic [63:0]        SQRT_TOP = 64'h4000_0000_0000_0000;

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7FFF_FFFF;
    else if (v < -64'sd2147483648) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  // Unsigned 64-bit add that sticks at all ones.
  function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? {64{1'b1}} : s[63:0];
  endfunction

  logic [lmp_pkg::OPC_W-1:0]   op_r;
  logic [lmp_pkg::IDX_W-1:0]   idx_r;
  logic signed [31:0]          val_r;
  logic [lmp_pkg::FC_W-1:0]    fc_r;
  logic signed [31:0]          mean_r;
  logic signed [31:0]          coef_r [MAX_FEATURES+1];
  logic [FS_W-1:0]             fs_r;
  logic signed [63:0]          dot_r;
  logic [63:0]                 rss_r, tss_r;
  logic [ROW_COUNT_BITS-1:0]   rows_r;
  logic signed [65:0]          mul_r;
  logic signed [31:0]          pred_r, res_r;
  logic [31:0]                 mag_rss_r, mag_tss_r;
  logic [63:0]                 div_rem_r, div_den_r;
  logic [Q_W-1:0]              div_quo_r;
  logic [QC_W-1:0]             div_cnt_r;
  logic [63:0]                 sv_r, sres_r, sbit_r;
  logic [31:0]                 rms_r;
  logic signed [31:0]          r2_r;

  logic [FS_W-1:0]             fs_inc;
  logic signed [31:0]          coef_sel;
  logic                        fs_lt_max, fs_lt_stop;
  logic signed [32:0]          mul_a, mul_b;
  logic signed [65:0]          prod_scaled;
  logic [63:0]                 sq_scaled;
  logic signed [63:0]          psum;
  logic signed [32:0]          d_rss, d_tss, e_res;
  logic [64:0]                 div_t, div_sub;
  logic                        div_ge;
  logic [63:0]                 sq_in, s_rb;
  logic [Q_W-1:0]              r2_q;
  logic signed [63:0]          r2_w;

  // Coefficient for the next feature and row position tests.
  assign fs_inc     = fs_r + 1'b1;
  assign coef_sel   = coef_r[fs_inc[CI_W-1:0]];
  assign fs_lt_max  = 32'(fs_r) < MAX_FEATURES;
  assign fs_lt_stop = 32'(fs_r) < (MAX_FEATURES + 1);

  // Shared multiplier operands: feature times coefficient, or a square.
  always_comb begin
    case (cmd.mul_sel)
      lmp_pkg::MS_RSS: begin
        mul_a = {1'b0, mag_rss_r};
        mul_b = {1'b0, mag_rss_r};
      end
      lmp_pkg::MS_TSS: begin
        mul_a = {1'b0, mag_tss_r};
        mul_b = {1'b0, mag_tss_r};
      end
      default: begin
        mul_a = {val_r[31], val_r};
        mul_b = {coef_sel[31], coef_sel};
      end
    endcase
  end

  // Scaled products, prediction sum and row differences.
  assign prod_scaled = mul_r >>> FRAC_BITS;
  assign sq_scaled   = mul_r[63:0] >> FRAC_BITS;
  assign psum        = {{32{coef_r[0][31]}}, coef_r[0]} + dot_r;
  assign d_rss       = {val_r[31], val_r} - {pred_r[31], pred_r};
  assign d_tss       = {val_r[31], val_r} - {mean_r[31], mean_r};
  assign e_res       = {pred_r[31], pred_r} - {val_r[31], val_r};

  // One restoring divider step per cycle.
  assign div_t   = {div_rem_r, div_quo_r[Q_W-1]};
  assign div_sub = div_t - {1'b0, div_den_r};
  assign div_ge  = div_t >= {1'b0, div_den_r};

  // Mean square saturated to 64 bits, and the root step sum.
  assign sq_in = (|div_quo_r[Q_W-1:64]) ? {64{1'b1}} : div_quo_r[63:0];
  assign s_rb  = sres_r + sbit_r;

  // Ratio capped before it is taken from one.
  assign r2_q = (div_quo_r > R2_CAP) ? R2_CAP : div_quo_r;
  assign r2_w = ONE_FX - $signed({1'b0, r2_q[62:0]});

  // Control state: configuration, coefficients, accumulators and counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fc_r   <= lmp_pkg::FC_W'(1);
      mean_r <= '0;
      for (int i = 0; i <= MAX_FEATURES; i++) coef_r[i] <= '0;
      fs_r   <= '0;
      dot_r  <= '0;
      rss_r  <= '0;
      tss_r  <= '0;
      rows_r <= '0;
      sbit_r <= '0;
      div_cnt_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          lmp_pkg::CFG_FEATURE_COUNT: fc_r <= cfg_data[lmp_pkg::FC_W-1:0];
          lmp_pkg::CFG_RESPONSE_MEAN: mean_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.coef_wr) begin
        for (int i = 0; i <= MAX_FEATURES; i++) begin
          if (32'(idx_r) == i) coef_r[i] <= val_r;
        end
      end
      if (cmd.acc_feat) begin
        if (fs_lt_max) dot_r <= dot_r + prod_scaled[63:0];
        if (fs_lt_stop) fs_r <= fs_inc;
      end
      if (cmd.close) begin
        dot_r <= '0;
        fs_r  <= '0;
      end
      if (cmd.add_rss) rss_r <= sat_add64(rss_r, sq_scaled);
      if (cmd.add_tss) begin
        tss_r <= sat_add64(tss_r, sq_scaled);
        if (rows_r != {ROW_COUNT_BITS{1'b1}}) rows_r <= rows_r + 1'b1;
      end
      if (cmd.out_load && cmd.out_sel == lmp_pkg::RS_STAT) begin
        rss_r  <= '0;
        tss_r  <= '0;
        rows_r <= '0;
      end
      if (cmd.div_start) div_cnt_r <= QC_W'(Q_W);
      else if (cmd.div_step) div_cnt_r <= div_cnt_r - 1'b1;
      if (cmd.sqrt_start) sbit_r <= SQRT_TOP;
      else if (cmd.sqrt_step) sbit_r <= sbit_r >> 2;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_opcode;
      idx_r <= in_coef_index;
      val_r <= in_value;
    end
    if (cmd.mul_en) mul_r <= mul_a * mul_b;
    if (cmd.close) pred_r <= sat32(psum);
    if (cmd.diff) begin
      mag_rss_r <= d_rss[32] ? 32'(-d_rss) : d_rss[31:0];
      mag_tss_r <= d_tss[32] ? 32'(-d_tss) : d_tss[31:0];
      res_r     <= (e_res[32] != e_res[31]) ? (e_res[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
                                            : e_res[31:0];
    end
    if (cmd.div_start) begin
      div_rem_r <= '0;
      div_quo_r <= {rss_r, {FRAC_BITS{1'b0}}};
      div_den_r <= cmd.div_tss ? tss_r : 64'(rows_r);
    end else if (cmd.div_step) begin
      div_rem_r <= div_ge ? div_sub[63:0] : div_t[63:0];
      div_quo_r <= {div_quo_r[Q_W-2:0], div_ge};
    end
    if (cmd.sqrt_start) begin
      sv_r   <= sq_in;
      sres_r <= '0;
    end else if (cmd.sqrt_step) begin
      if (sv_r >= s_rb) begin
        sv_r   <= sv_r - s_rb;
        sres_r <= (sres_r >> 1) + sbit_r;
      end else begin
        sres_r <= sres_r >> 1;
      end
    end
    if (cmd.rms_load) rms_r <= sres_r[31:0];
    if (cmd.r2_load) r2_r <= sat32(r2_w);
  end

  // Result word register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_kind      <= lmp_pkg::KIND_ROW;
      out_predicted <= '0;
      out_residual  <= '0;
      out_r_squared <= '0;
      out_rms_error <= '0;
      out_status    <= lmp_pkg::ST_OK;
      case (cmd.out_sel)
        lmp_pkg::RS_MISS: out_status <= lmp_pkg::ST_MISMATCH;
        lmp_pkg::RS_PRED: out_predicted <= pred_r;
        lmp_pkg::RS_ROW: begin
          out_predicted <= pred_r;
          out_residual  <= res_r;
        end
        lmp_pkg::RS_STAT: begin
          out_kind <= lmp_pkg::KIND_STAT;
          if (rows_r == '0) begin
            out_status <= lmp_pkg::ST_NO_ROWS;
          end else if (tss_r == '0) begin
            out_status    <= lmp_pkg::ST_ZERO_TSS;
            out_rms_error <= rms_r;
          end else begin
            out_r_squared <= r2_r;
            out_rms_error <= rms_r;
          end
        end
        default: ;
      endcase
    end
  end

  // Status toward the controller.
  always_comb begin
    stat.opcode    = op_r;
    stat.match     = (32'(fc_r) <= MAX_FEATURES) && (32'(fs_r) == 32'(fc_r));
    stat.rows_zero = (rows_r == '0);
    stat.tss_zero  = (tss_r == '0);
    stat.div_done  = (div_cnt_r == '0);
    stat.sqrt_done = (sbit_r == '0);
  end

endmodule

@@ rtl/core/linear_model_predict_with_fit_stats.sv @@
// After acceptance a load writes a coefficient, a feature is multiplied, then added;
// a close emits at once (predict only or count mismatch) or sums squared errors first
// (observed y); finish emits at once with no rows, else divides, takes the root and,
// unless tss is zero, divides again. A stalled result holds the block. One word at a time.
// Reset is synchronous, active low: coefficients, sums, counts and the output
// valid clear, feature_count returns to 1 and response_mean to 0.
module linear_model_predict_with_fit_stats #(
  parameter int MAX_FEATURES   = lmp_pkg::MAX_FEATURES_DEF,
  parameter int FRAC_BITS      = lmp_pkg::FRAC_BITS_DEF,
  parameter int ROW_COUNT_BITS = lmp_pkg::ROW_COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  lmp_in_if.sink                          in_ch,
  lmp_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [lmp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lmp_pkg::VAL_W-1:0]       cfg_data
);

  lmp_pkg::lmp_cmd_t   cmd;
  lmp_pkg::lmp_stat_t  stat;

  // Sequencer.
  lmp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Arithmetic and state.
  lmp_datapath #(
    .MAX_FEATURES   (MAX_FEATURES),
    .FRAC_BITS      (FRAC_BITS),
    .ROW_COUNT_BITS (ROW_COUNT_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_opcode     (in_ch.opcode),
    .in_coef_index (in_ch.coef_index),
    .in_value      (in_ch.value),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_kind      (out_ch.kind),
    .out_predicted (out_ch.predicted),
    .out_residual  (out_ch.residual),
    .out_r_squared (out_ch.r_squared),
    .out_rms_error (out_ch.rms_error),
    .out_status    (out_ch.status)
  );

endmodule

@@ rtl/core/lmp_checker.sv @@
`include "linear_model_predict_with_fit_stats_defines.svh"

module lmp_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           out_kind,
  input logic [lmp_pkg::VAL_W-1:0]      out_predicted,
  input logic [lmp_pkg::VAL_W-1:0]      out_residual,
  input logic [lmp_pkg::ST_W-1:0]       out_status
);

  logic row_bad;
  logic row_fault_ok;

  // Row words with a bad status, and the shape such a word must have.
  assign row_bad      = out_valid && out_kind == lmp_pkg::KIND_ROW &&
                        out_status != lmp_pkg::ST_OK;
  assign row_fault_ok = out_status == lmp_pkg::ST_MISMATCH && out_predicted == '0 &&
                        out_residual == '0;

  // A stalled result word stays offered.
  `LMP_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid)

  // A word is worked on alone, so input closes right after an acceptance.
  `LMP_ASSERT(a_one_in_flight, in_valid && in_ready |=> !in_ready)

  // A row result with bad status is a count mismatch with zero payload.
  `LMP_ASSERT(a_row_fault, row_bad |-> row_fault_ok)

  // Leaving reset, the block is empty and ready for a word.
  `LMP_ASSERT_RST(a_reset_idle, !rst_n |=> !out_valid && in_ready)

endmodule

bind linear_model_predict_with_fit_stats lmp_checker u_lmp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_kind      (out_ch.kind),
  .out_predicted (out_ch.predicted),
  .out_residual  (out_ch.residual),
  .out_status    (out_ch.status)
);

@@ tb/linear_model_predict_with_fit_stats_test.sv @@
`timescale 1ns / 100ps

module linear_model_predict_with_fit_stats_test;
  import lmp_pkg::*;

  // One input word as the sender offers it.
  typedef struct packed {
    logic [OPC_W-1:0] op;
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] val;
  } lm_word_t;

  // One result word as the block returns it.
  typedef struct packed {
    logic             kind;
    logic [VAL_W-1:0] predicted;
    logic [VAL_W-1:0] residual;
    logic [VAL_W-1:0] r_squared;
    logic [VAL_W-1:0] rms_error;
    logic [ST_W-1:0]  status;
  } lm_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [VAL_W-1:0] cfg_data;

  lmp_in_if in_ch ();
  lmp_out_if out_ch ();

  linear_model_predict_with_fit_stats dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predictor state, mirroring the block's registers.
  logic signed [VAL_W-1:0] coef_mem [0:16];
  longint dot_acc;
  int unsigned feat_seen;
  logic [63:0] rss_sum;
  logic [63:0] tss_sum;
  int unsigned row_cnt;
  logic [FC_W-1:0] feat_cnt_reg;
  logic signed [VAL_W-1:0] mean_reg;

  lm_word_t pending_words[$];
  lm_result_t expected_results[$];
  lm_word_t cur_word;

  int err_cnt;
  int words_sent;
  int row_results;
  int stat_results;
  int status_seen [0:3];
  bit idle_en;
  int gap_left;
  int stall_left;
  int hold_left;
  int hold_req;

  always #1 clk = ~clk;

  function automatic longint sat32(longint v);
    if (v > 64'sh7FFFFFFF) return 64'sh7FFFFFFF;
    if (v < -64'sh80000000) return -64'sh80000000;
    return v;
  endfunction

  // Squares a difference clamped to 32 bits, drops the fraction and adds with saturation.
  function automatic logic [63:0] add_square(logic [63:0] sum, longint d);
    logic [63:0] m;
    logic [64:0] t;
    m = (d < 0) ? -d : d;
    if (m > 64'hFFFFFFFF) m = 64'hFFFFFFFF;
    t = {1'b0, sum} + {1'b0, (m * m) >> 16};
    return t[64] ? 64'hFFFFFFFFFFFFFFFF : t[63:0];
  endfunction

  // Fixed-point quotient num/den with 16 fraction bits, capped.
  function automatic logic [63:0] frac_quotient(logic [63:0] num, logic [63:0] den,
                                                logic [63:0] cap);
    logic [63:0] q;
    logic [63:0] r;
    logic b;
    q = num / den;
    r = num % den;
    if (q > cap) return cap;
    for (int i = 0; i < 16; i++) begin
      if (r >= den - r) begin
        b = 1'b1;
        r = r - (den - r);
      end else begin
        b = 1'b0;
        r = r << 1;
      end
      if (q > (cap >> 1)) return cap;
      q = (q << 1) | b;
      if (q > cap) return cap;
    end
    return q;
  endfunction

  function automatic logic [63:0] int_root(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Applies one accepted word to the predictor; returns 1 when it yields a result.
  function automatic bit evaluate_word(lm_word_t w, output lm_result_t r);
    longint sv;
    longint pred;
    logic [63:0] ms;
    logic [63:0] q;
    bit match;
    sv = longint'($signed(w.val));
    r = '0;
    case (w.op)
      OP_LOAD: begin
        if (w.idx <= 16) coef_mem[w.idx] = w.val;
        return 0;
      end
      OP_FEATURE: begin
        if (feat_seen < 16) dot_acc += (sv * longint'(coef_mem[feat_seen + 1])) >>> 16;
        if (feat_seen < 17) feat_seen++;
        return 0;
      end
      OP_CLOSE_OBS, OP_CLOSE_PRED: begin
        match = (feat_cnt_reg <= 16) && (feat_seen == feat_cnt_reg);
        pred = sat32(longint'(coef_mem[0]) + dot_acc);
        dot_acc = 0;
        feat_seen = 0;
        r.kind = KIND_ROW;
        if (!match) begin
          r.status = ST_MISMATCH;
        end else if (w.op == OP_CLOSE_PRED) begin
          r.predicted = pred[31:0];
          r.status = ST_OK;
        end else begin
          rss_sum = add_square(rss_sum, sv - pred);
          tss_sum = add_square(tss_sum, sv - longint'(mean_reg));
          if (row_cnt < 65535) row_cnt++;
          r.predicted = pred[31:0];
          r.residual = VAL_W'(sat32(pred - sv));
          r.status = ST_OK;
        end
        return 1;
      end
      OP_FINISH: begin
        r.kind = KIND_STAT;
        if (row_cnt == 0) begin
          r.status = ST_NO_ROWS;
        end else begin
          ms = frac_quotient(rss_sum, 64'(row_cnt), 64'hFFFFFFFFFFFFFFFF);
          r.rms_error = VAL_W'(int_root(ms));
          if (tss_sum == 0) begin
            r.status = ST_ZERO_TSS;
          end else begin
            q = frac_quotient(rss_sum, tss_sum, 64'd1 << 40);
            r.r_squared = VAL_W'(sat32(longint'(65536) - longint'(q)));
            r.status = ST_OK;
          end
        end
        rss_sum = 0;
        tss_sum = 0;
        row_cnt = 0;
        return 1;
      end
      default: return 0;
    endcase
  endfunction

  // Driver: offers queued words and updates the predictor on each accepted word.
  always @(posedge clk) begin
    lm_result_t r;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        if (evaluate_word(cur_word, r)) expected_results.push_back(r);
        words_sent++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (idle_en && $urandom_range(0, 9) == 0) begin
          gap_left = $urandom_range(0, 15);
          in_ch.valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          cur_word = pending_words.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.opcode <= cur_word.op;
          in_ch.coef_index <= cur_word.idx;
          in_ch.value <= cur_word.val;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stalls the result side and checks each accepted result word.
  always @(posedge clk) begin
    lm_result_t e;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("result word with none expected");
          err_cnt++;
        end else begin
          e = expected_results.pop_front();
          if (out_ch.kind !== e.kind) begin
            $error("kind: expected %0d, got %0d", e.kind, out_ch.kind);
            err_cnt++;
          end
          if (out_ch.predicted !== e.predicted) begin
            $error("predicted: expected %h, got %h", e.predicted, out_ch.predicted);
            err_cnt++;
          end
          if (out_ch.residual !== e.residual) begin
            $error("residual: expected %h, got %h", e.residual, out_ch.residual);
            err_cnt++;
          end
          if (out_ch.r_squared !== e.r_squared) begin
            $error("r_squared: expected %h, got %h", e.r_squared, out_ch.r_squared);
            err_cnt++;
          end
          if (out_ch.rms_error !== e.rms_error) begin
            $error("rms_error: expected %h, got %h", e.rms_error, out_ch.rms_error);
            err_cnt++;
          end
          if (out_ch.status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, out_ch.status);
            err_cnt++;
          end
          if (e.kind == KIND_STAT) stat_results++;
          else row_results++;
          status_seen[e.status]++;
        end
      end
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 15);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic put(logic [OPC_W-1:0] op, logic [IDX_W-1:0] idx, logic [VAL_W-1:0] val);
    lm_word_t w;
    w.op = op;
    w.idx = idx;
    w.val = val;
    pending_words.push_back(w);
  endtask

  function automatic logic [VAL_W-1:0] pick_value(bit narrow);
    if (narrow) return VAL_W'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
    return $urandom;
  endfunction

  // Waits until every word is taken and every result is back, then lets the block drain.
  task automatic wait_quiet();
    do @(negedge clk);
    while (pending_words.size() != 0 || in_ch.valid || expected_results.size() != 0);
    repeat (260) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [VAL_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    if (idx == CFG_FEATURE_COUNT) feat_cnt_reg = data[FC_W-1:0];
    else mean_reg = data;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random phase: mostly well-formed rows with random content, some noise.
  task automatic random_phase(int n_words);
    int cnt;
    int pick;
    int nf;
    bit narrow;
    cnt = 0;
    narrow = $urandom_range(0, 3) != 0;
    for (int i = 0; i <= 16; i++) put(OP_LOAD, IDX_W'(i), pick_value(narrow));
    while (cnt < n_words) begin
      pick = $urandom_range(0, 99);
      narrow = $urandom_range(0, 9) < 7;
      if (pick < 8) begin
        put(OP_LOAD, IDX_W'($urandom_range(0, 31)), pick_value(narrow));
        cnt++;
      end else if (pick < 13) begin
        put(OPC_W'($urandom_range(5, 7)), IDX_W'($urandom), $urandom);
        put(OP_FEATURE, IDX_W'($urandom), pick_value(narrow));
        cnt += 2;
      end else if (pick < 20) begin
        nf = $urandom_range(0, 18);
        for (int i = 0; i < nf; i++) put(OP_FEATURE, IDX_W'($urandom), pick_value(narrow));
        put(OPC_W'($urandom_range(2, 3)), IDX_W'($urandom), pick_value(narrow));
        cnt += nf + 1;
      end else if (pick < 26) begin
        put(OP_FINISH, IDX_W'($urandom), $urandom);
        cnt++;
      end else begin
        nf = (feat_cnt_reg > 16) ? $urandom_range(0, 3) : feat_cnt_reg;
        for (int i = 0; i < nf; i++) put(OP_FEATURE, IDX_W'($urandom), pick_value(narrow));
        if ($urandom_range(0, 4) == 0) put(OP_CLOSE_PRED, IDX_W'($urandom), $urandom);
        else put(OP_CLOSE_OBS, IDX_W'($urandom), pick_value(narrow));
        cnt += nf + 1;
      end
    end
    put(OP_FINISH, '0, '0);
  endtask

  initial begin
    #2000000;
    $display("linear_model_predict_with_fit_stats_test: done, errors");
    $finish;
  end

  // Stimulus sequence.
  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.opcode = '0;
    in_ch.coef_index = '0;
    in_ch.value = '0;
    out_ch.ready = 1'b0;
    for (int i = 0; i <= 16; i++) coef_mem[i] = '0;
    dot_acc = 0;
    feat_seen = 0;
    rss_sum = 0;
    tss_sum = 0;
    row_cnt = 0;
    feat_cnt_reg = 1;
    mean_reg = 0;
    idle_en = 1'b1;
    hold_req = 0;
    hold_left = 0;
    gap_left = 0;
    stall_left = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset defaults: finish with no rows, a close with too few features,
    // unknown opcodes and loads into slots past the store.
    put(OP_FINISH, '0, '0);
    put(OP_CLOSE_OBS, '0, 32'h0001_0000);
    put(OP_FEATURE, '0, 32'h0003_0000);
    put(OP_CLOSE_PRED, '0, '0);
    put(3'd5, 5'd31, 32'hFFFF_FFFF);
    put(3'd6, '0, '0);
    put(3'd7, '0, '0);
    put(OP_LOAD, 5'd31, 32'h7FFF_FFFF);
    put(OP_LOAD, 5'd17, 32'h7FFF_FFFF);
    wait_quiet();

    // Extreme coefficients and features, saturation, zero tss, no rows.
    write_reg(CFG_FEATURE_COUNT, 2);
    write_reg(CFG_RESPONSE_MEAN, 32'h0001_8000);
    put(OP_LOAD, 5'd0, 32'h7FFF_FFFF);
    put(OP_LOAD, 5'd1, 32'h8000_0000);
    put(OP_LOAD, 5'd2, 32'h0001_0000);
    put(OP_FEATURE, '0, 32'h7FFF_FFFF);
    put(OP_FEATURE, '0, 32'h8000_0000);
    put(OP_CLOSE_OBS, '0, 32'h8000_0000);
    put(OP_FEATURE, '0, 32'h0001_0000);
    put(OP_FEATURE, '0, 32'hFFFF_0000);
    put(OP_CLOSE_PRED, '0, '0);
    for (int i = 0; i < 3; i++) put(OP_FEATURE, '0, 32'h0000_8000);
    put(OP_CLOSE_OBS, '0, '0);
    put(OP_FINISH, '0, '0);
    put(OP_LOAD, 5'd0, 32'h0000_4000);
    put(OP_FEATURE, '0, '0);
    put(OP_FEATURE, '0, '0);
    put(OP_CLOSE_OBS, '0, 32'h0001_8000);
    put(OP_FINISH, '0, '0);
    put(OP_FINISH, '0, '0);
    wait_quiet();

    // Feature count above the store, zero count and extra features.
    write_reg(CFG_FEATURE_COUNT, 31);
    write_reg(CFG_RESPONSE_MEAN, 32'h7FFF_FFFF);
    put(OP_FEATURE, '0, 32'h0002_0000);
    put(OP_CLOSE_OBS, '0, 32'h0002_0000);
    wait_quiet();
    write_reg(CFG_FEATURE_COUNT, 0);
    write_reg(CFG_RESPONSE_MEAN, 32'h8000_0000);
    put(OP_CLOSE_OBS, '0, 32'h7FFF_FFFF);
    put(OP_FINISH, '0, '0);
    wait_quiet();
    write_reg(CFG_FEATURE_COUNT, 16);
    for (int i = 0; i < 18; i++) put(OP_FEATURE, '0, 32'h0001_0000);
    put(OP_CLOSE_OBS, '0, 32'h0001_0000);
    wait_quiet();

    // Random phases over several settings.
    write_reg(CFG_RESPONSE_MEAN, $urandom);
    random_phase(80);
    wait_quiet();
    write_reg(CFG_FEATURE_COUNT, 1);
    write_reg(CFG_RESPONSE_MEAN, 0);
    hold_req = 200;
    random_phase(80);
    wait_quiet();
    write_reg(CFG_FEATURE_COUNT, FC_W'($urandom_range(1, 16)));
    write_reg(CFG_RESPONSE_MEAN, VAL_W'($signed($urandom_range(0, 8 << 16)) - (4 << 16)));
    random_phase(90);
    wait_quiet();
    write_reg(CFG_FEATURE_COUNT, FC_W'($urandom_range(1, 16)));
    write_reg(CFG_RESPONSE_MEAN, $urandom);
    random_phase(90);
    wait_quiet();
    write_reg(CFG_FEATURE_COUNT, FC_W'($urandom_range(2, 5)));
    write_reg(CFG_RESPONSE_MEAN, '0);
    idle_en = 1'b0;
    random_phase(70);
    wait_quiet();

    $display("Sent %0d words; checked %0d row and %0d statistics results.",
             words_sent, row_results, stat_results);
    $display("Status counts: ok %0d, count mismatch %0d, zero tss %0d, no rows %0d.",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (err_cnt == 0) begin
      $display("linear_model_predict_with_fit_stats_test: done, clean");
    end else begin
      $display("linear_model_predict_with_fit_stats_test: done, errors");
    end
    $finish;
  end

endmodule
